/* hw/rtl/siph_pkg.sv */
// Shared types, constants and the SipRound function of the SipHash-2-4 block.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing else.
package siph_pkg;

    localparam int unsigned LANE_W = 64;
    localparam int unsigned BUF_W  = 56;
    localparam int unsigned CNT_W  = 8;

    // Initialization constants of the scheme.
    localparam logic [LANE_W-1:0] INIT_A = 64'h736f6d6570736575;
    localparam logic [LANE_W-1:0] INIT_B = 64'h646f72616e646f6d;
    localparam logic [LANE_W-1:0] INIT_C = 64'h6c7967656e657261;
    localparam logic [LANE_W-1:0] INIT_D = 64'h7465646279746573;
    localparam logic [LANE_W-1:0] TAG128_MARK = 64'h00000000000000ee;
    localparam logic [LANE_W-1:0] SECOND_MARK = 64'h00000000000000dd;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_KEY_HALF0 = 1'b0,
        CFG_KEY_HALF1 = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_empty;
    } t_siph_in;

    typedef struct packed {
        logic [LANE_W-1:0] hash_first;
        logic [LANE_W-1:0] hash_second;
    } t_siph_out;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
        logic [LANE_W-1:0] d;
    } t_lanes;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        DP_HOLD     = 3'd0,
        DP_ACCEPT   = 3'd1,
        DP_ROUND    = 3'd2,
        DP_ROUND_XA = 3'd3,
        DP_FIN_LOAD = 3'd4,
        DP_FIN_C    = 3'd5,
        DP_CAP0     = 3'd6,
        DP_CAP1     = 3'd7
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MSG_RND,
        S_FIN_LOAD,
        S_FIN_ABS,
        S_FIN_C,
        S_FIN_R1,
        S_CAP0,
        S_FIN_R2,
        S_CAP1
    } t_siph_state;

    typedef struct packed {
        t_dp_op op;
    } t_siph_cmd;

    typedef struct packed {
        logic full_word;
        logic msg_end;
    } t_siph_sts;

    // One SipRound over the four lanes.
    function automatic t_lanes sip_round(input t_lanes v);
        t_lanes r;
        r = v;
        r.a = r.a + r.b;
        r.c = r.c + r.d;
        r.b = {r.b[50:0], r.b[63:51]};
        r.d = {r.d[47:0], r.d[63:48]};
        r.b = r.b ^ r.a;
        r.d = r.d ^ r.c;
        r.a = {r.a[31:0], r.a[63:32]};
        r.c = r.c + r.b;
        r.a = r.a + r.d;
        r.b = {r.b[46:0], r.b[63:47]};
        r.d = {r.d[42:0], r.d[63:43]};
        r.b = r.b ^ r.c;
        r.d = r.d ^ r.a;
        r.c = {r.c[31:0], r.c[63:32]};
        return r;
    endfunction

endpackage

/* hw/rtl/siph_ctrl.sv */
// Controller state machine of the SipHash-2-4 block.
// Sequences rounds and finalization and owns the input and output handshakes.
// Depends on siph_pkg.
module siph_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  siph_pkg::t_siph_sts i_sts,
    output siph_pkg::t_siph_cmd o_cmd
);

    siph_pkg::t_siph_state r_state, n_state;
    logic [1:0]            r_rnd, n_rnd;
    logic                  r_fin, n_fin;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            siph_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.full_word) begin
                        n_state = siph_pkg::S_MSG_RND;
                    end else if (i_sts.msg_end) begin
                        n_state = siph_pkg::S_FIN_LOAD;
                    end
                end
            end
            siph_pkg::S_MSG_RND: begin
                if (r_rnd == 2'd1) begin
                    n_state = r_fin ? siph_pkg::S_FIN_LOAD : siph_pkg::S_IDLE;
                end
            end
            siph_pkg::S_FIN_LOAD: n_state = siph_pkg::S_FIN_ABS;
            siph_pkg::S_FIN_ABS: begin
                if (r_rnd == 2'd1) begin
                    n_state = siph_pkg::S_FIN_C;
                end
            end
            siph_pkg::S_FIN_C: n_state = siph_pkg::S_FIN_R1;
            siph_pkg::S_FIN_R1: begin
                if (r_rnd == 2'd3) begin
                    n_state = siph_pkg::S_CAP0;
                end
            end
            siph_pkg::S_CAP0: n_state = siph_pkg::S_FIN_R2;
            siph_pkg::S_FIN_R2: begin
                if (r_rnd == 2'd3) begin
                    n_state = siph_pkg::S_CAP1;
                end
            end
            siph_pkg::S_CAP1: begin
                if (out_free) begin
                    n_state = siph_pkg::S_IDLE;
                end
            end
            default: n_state = siph_pkg::S_IDLE;
        endcase
    end

    // Outputs and counters.
    always_comb begin
        o_cmd.op    = siph_pkg::DP_HOLD;
        n_rnd       = 2'd0;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            siph_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = siph_pkg::DP_ACCEPT;
                    n_fin    = i_sts.msg_end;
                end
            end
            siph_pkg::S_MSG_RND, siph_pkg::S_FIN_ABS: begin
                o_cmd.op = (r_rnd == 2'd1) ? siph_pkg::DP_ROUND_XA : siph_pkg::DP_ROUND;
                n_rnd    = (r_rnd == 2'd1) ? 2'd0 : r_rnd + 2'd1;
            end
            siph_pkg::S_FIN_R1, siph_pkg::S_FIN_R2: begin
                o_cmd.op = siph_pkg::DP_ROUND;
                n_rnd    = r_rnd + 2'd1;
            end
            siph_pkg::S_FIN_LOAD: o_cmd.op = siph_pkg::DP_FIN_LOAD;
            siph_pkg::S_FIN_C:    o_cmd.op = siph_pkg::DP_FIN_C;
            siph_pkg::S_CAP0:     o_cmd.op = siph_pkg::DP_CAP0;
            siph_pkg::S_CAP1: begin
                if (out_free) begin
                    o_cmd.op    = siph_pkg::DP_CAP1;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.op = siph_pkg::DP_HOLD;
        endcase
    end

    assign o_in_stall  = (r_state != siph_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= siph_pkg::S_IDLE;
            r_rnd       <= 2'd0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hw/rtl/siph_dp.sv */
// Datapath of the SipHash-2-4 block: key registers, lanes, byte packing,
// one SipRound per cycle and the result register. Depends on siph_pkg.
module siph_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  siph_pkg::t_cfg_idx  i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  siph_pkg::t_siph_in  i_in_data,
    input  siph_pkg::t_siph_cmd i_cmd,
    output siph_pkg::t_siph_sts o_sts,
    output siph_pkg::t_siph_out o_out_data
);

    logic [siph_pkg::LANE_W-1:0] r_key0, r_key1;
    siph_pkg::t_lanes            r_lanes, n_lanes;
    siph_pkg::t_lanes            base_lanes, init_lanes, rnd_lanes;
    logic [siph_pkg::LANE_W-1:0] r_msg, n_msg;
    logic [siph_pkg::BUF_W-1:0]  r_buf, n_buf, base_buf, buf_ins;
    logic [siph_pkg::CNT_W-1:0]  r_cnt, n_cnt, base_cnt;
    logic                        r_in_msg, n_in_msg;
    logic [siph_pkg::LANE_W-1:0] r_h0, n_h0, tag;
    siph_pkg::t_siph_out         r_out, n_out;
    logic [2:0]                  pos;
    logic [siph_pkg::LANE_W-1:0] full_m, fin_m;
    logic                        full_word, msg_end;

    always_comb begin
        init_lanes.a = r_key0 ^ siph_pkg::INIT_A;
        init_lanes.b = r_key1 ^ siph_pkg::INIT_B ^ siph_pkg::TAG128_MARK;
        init_lanes.c = r_key0 ^ siph_pkg::INIT_C;
        init_lanes.d = r_key1 ^ siph_pkg::INIT_D;
    end

    // A new message starts from the key and an empty buffer.
    assign base_lanes = r_in_msg ? r_lanes : init_lanes;
    assign base_buf   = r_in_msg ? r_buf : '0;
    assign base_cnt   = r_in_msg ? r_cnt : '0;
    assign pos        = base_cnt[2:0];
    assign full_word  = !i_in_data.is_empty && (pos == 3'd7);
    assign msg_end    = i_in_data.last_byte || i_in_data.is_empty;
    assign full_m     = {i_in_data.data_byte, base_buf};
    assign buf_ins    = base_buf | (siph_pkg::BUF_W'(i_in_data.data_byte) << {pos, 3'b000});
    assign fin_m      = {r_cnt, r_buf};
    assign rnd_lanes  = siph_pkg::sip_round(r_lanes);
    assign tag        = r_lanes.a ^ r_lanes.b ^ r_lanes.c ^ r_lanes.d;

    assign o_sts.full_word = full_word;
    assign o_sts.msg_end   = msg_end;

    always_comb begin
        n_lanes  = r_lanes;
        n_msg    = r_msg;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_in_msg = r_in_msg;
        n_h0     = r_h0;
        n_out    = r_out;
        unique case (i_cmd.op)
            siph_pkg::DP_HOLD: ;
            siph_pkg::DP_ACCEPT: begin
                n_lanes = base_lanes;
                if (full_word) begin
                    n_lanes.d = base_lanes.d ^ full_m;
                end
                n_msg = full_m;
                if (i_in_data.is_empty) begin
                    n_buf = base_buf;
                    n_cnt = base_cnt;
                end else begin
                    n_buf = full_word ? '0 : buf_ins;
                    n_cnt = base_cnt + 8'd1;
                end
                n_in_msg = !msg_end;
            end
            siph_pkg::DP_ROUND: n_lanes = rnd_lanes;
            siph_pkg::DP_ROUND_XA: begin
                n_lanes   = rnd_lanes;
                n_lanes.a = rnd_lanes.a ^ r_msg;
            end
            siph_pkg::DP_FIN_LOAD: begin
                n_lanes.d = r_lanes.d ^ fin_m;
                n_msg     = fin_m;
            end
            siph_pkg::DP_FIN_C: n_lanes.c = r_lanes.c ^ siph_pkg::TAG128_MARK;
            siph_pkg::DP_CAP0: begin
                n_h0      = tag;
                n_lanes.b = r_lanes.b ^ siph_pkg::SECOND_MARK;
            end
            siph_pkg::DP_CAP1: begin
                n_out.hash_first  = r_h0;
                n_out.hash_second = tag;
            end
            default: ;
        endcase
    end

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0   <= '0;
            r_key1   <= '0;
            r_in_msg <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == siph_pkg::CFG_KEY_HALF0)) begin
                r_key0 <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == siph_pkg::CFG_KEY_HALF1)) begin
                r_key1 <= i_cfg_data;
            end
            r_in_msg <= n_in_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_msg   <= n_msg;
        r_buf   <= n_buf;
        r_cnt   <= n_cnt;
        r_h0    <= n_h0;
        r_out   <= n_out;
    end

endmodule

/* hw/rtl/siphash_2_4_128_keyed_hash.sv */
// Top level of the keyed SipHash-2-4 block with a 128-bit tag.
// Joins the controller and the datapath. Depends on siph_pkg, siph_ctrl and siph_dp.
//
// The block hashes a byte stream with SipHash-2-4 and returns a 128-bit tag as
// two 64-bit words. Software writes the two key halves through the configuration
// channel (index 0 and 1); the key is sampled when the first word of a message is
// accepted, so a write between messages takes effect with the next one. Each
// input word carries one message byte, an end flag and an empty-message marker.
// A byte that does not fill a 64-bit message word is only packed into the
// buffer. The eighth byte of a word is absorbed with two SipRounds, which run
// on the single round unit of the datapath, one round per cycle. A word that ends
// a message and fills a message word is first absorbed that way; then the final
// word is absorbed with two rounds, and two finalizations of four rounds each
// run on the same unit, with a separate step for each load and tag capture. The
// tag sits in an output register; the block takes new input words while an
// earlier tag still waits to be taken, and stalls only when a second tag is
// ready before the first has left. Input is stalled whenever a word is still
// being worked on. The configuration channel is always ready.
module siphash_2_4_128_keyed_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  siph_pkg::t_cfg_idx  i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  siph_pkg::t_siph_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output siph_pkg::t_siph_out o_out_data
);

    siph_pkg::t_siph_cmd cmd;
    siph_pkg::t_siph_sts sts;

    // Key registers have no hazard with the datapath, so writes are always taken.
    assign o_cfg_ready = 1'b1;

    siph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    siph_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/siph_chk.sv */
// Port-level checker for the SipHash-2-4 block, bound to the top level.
// Depends on siph_pkg.
module siph_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input siph_pkg::t_siph_in  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input siph_pkg::t_siph_out o_out_data
);

    // A stalled tag stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("tag word dropped while stalled");

    // A stalled tag does not change.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("tag word changed while stalled");

    // A word that does not end a message never produces a tag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_in_data.last_byte && !i_in_data.is_empty
        |=> !$rose(o_out_valid))
        else $error("tag appeared after a word that does not end a message");

    // Finalization always holds off the next input word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.last_byte || i_in_data.is_empty)
        |=> o_in_stall)
        else $error("input taken during finalization");

endmodule

bind siphash_2_4_128_keyed_hash siph_chk u_siph_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
